/* sv/u8d_pkg.sv */
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;

  // Byte class masks and tags
  localparam logic [ByteW-1:0] CONT_MASK  = 8'hC0;
  localparam logic [ByteW-1:0] CONT_TAG   = 8'h80;
  localparam logic [ByteW-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_TAG  = 8'hC0;
  localparam logic [ByteW-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [ByteW-1:0] LEAD3_TAG  = 8'hE0;
  localparam logic [ByteW-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [ByteW-1:0] LEAD4_TAG  = 8'hF0;

  // Codepoint limits
  localparam logic [CpW-1:0] MIN_2BYTE = 21'h000080;
  localparam logic [CpW-1:0] MIN_3BYTE = 21'h000800;
  localparam logic [CpW-1:0] MIN_4BYTE = 21'h010000;
  localparam logic [CpW-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [CpW-1:0] CP_MAX    = 21'h10FFFF;

  // Sequence lengths
  localparam logic [LenW-1:0] LEN_NONE = 3'd0;
  localparam logic [LenW-1:0] LEN_1    = 3'd1;
  localparam logic [LenW-1:0] LEN_2    = 3'd2;
  localparam logic [LenW-1:0] LEN_3    = 3'd3;
  localparam logic [LenW-1:0] LEN_4    = 3'd4;

  // Results of one input byte: pre errors, optional tail word, trailing errors
  typedef struct packed {
    logic [2:0]      cnt;
    logic [1:0]      pre;
    logic            tail_on;
    logic [CpW-1:0]  tail_cp;
    logic            tail_bad;
    logic [LenW-1:0] tail_len;
    logic            eot;
  } desc_t;

endpackage

/* sv/u8d_in_if.sv */
interface u8d_in_if import u8d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* sv/u8d_out_if.sv */
interface u8d_out_if import u8d_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CpW-1:0]  code_point;
  logic            bad_sequence;
  logic [LenW-1:0] byte_length;
  logic            end_of_text;

  modport source (output valid, output code_point, output bad_sequence,
                  output byte_length, output end_of_text, input ready);
  modport sink   (input valid, input code_point, input bad_sequence,
                  input byte_length, input end_of_text, output ready);
endinterface

/* sv/utf8_stream_decoder.sv */
// Strict UTF-8 decoder: one byte word in, codepoint words out. Sequence state
// is updated in the cycle a byte is accepted, and the words that byte causes
// (up to four: flushed held bytes, a codepoint or error, and end-of-text
// flushes) are captured in one result register that drains one word per
// cycle while the output is ready, so ordinary text streams at one byte per
// cycle when the output keeps up; a byte causing more than one word holds
// the input while the register drains. Input is taken again in the cycle the
// last word of the previous byte is taken. Errors come out as bad_sequence
// with code_point 0 and byte_length 1.
module utf8_stream_decoder import u8d_pkg::*; (
  input logic      clk,
  input logic      rst,
  u8d_in_if.sink   bytes,
  u8d_out_if.source codes
);

  // Sequence state
  logic [1:0]       held_count, held_count_next;
  logic [LenW-1:0]  seq_total, seq_total_next;
  logic [ByteW-1:0] held [3];

  // Result register
  desc_t      desc, desc_next;
  logic       desc_valid;
  logic [1:0] idx;

  logic             in_fire, out_fire, out_done, last_idx, tail_here;
  logic [ByteW-1:0] b;
  logic             is_cont, is_ascii;
  logic [LenW-1:0]  lead_tot;
  logic [CpW-1:0]   v2, v3, v4, fin_cp;
  logic             fin_ok;
  logic             do_lead, wr_lead, wr_store;
  logic [1:0]       post;

  assign b        = bytes.in_byte;
  assign in_fire  = bytes.valid && bytes.ready;
  assign out_fire = codes.valid && codes.ready;
  assign last_idx = ({1'b0, idx} == desc.cnt - 3'd1);
  assign out_done = out_fire && last_idx;

  assign bytes.ready = !desc_valid || out_done;

  // Byte classification
  always_comb begin
    is_cont  = (b & CONT_MASK) == CONT_TAG;
    is_ascii = !b[ByteW-1];
    if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      lead_tot = LEN_2;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      lead_tot = LEN_3;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      lead_tot = LEN_4;
    end else begin
      lead_tot = LEN_NONE;
    end
  end

  // Candidate codepoints for a closing continuation byte
  always_comb begin
    v2 = {10'd0, held[0][4:0], b[5:0]};
    v3 = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
    v4 = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
    case (seq_total)
      LEN_2: begin
        fin_cp = v2;
        fin_ok = v2 >= MIN_2BYTE;
      end
      LEN_3: begin
        fin_cp = v3;
        fin_ok = (v3 >= MIN_3BYTE) && !((v3 >= SURR_LO) && (v3 <= SURR_HI));
      end
      default: begin
        fin_cp = v4;
        fin_ok = (v4 >= MIN_4BYTE) && (v4 <= CP_MAX);
      end
    endcase
  end

  // Next state and result set for the incoming byte
  always_comb begin
    held_count_next = held_count;
    seq_total_next  = seq_total;
    desc_next       = '0;
    desc_next.tail_len = LEN_1;
    do_lead  = 1'b0;
    wr_lead  = 1'b0;
    wr_store = 1'b0;
    post     = 2'd0;

    if (held_count == 2'd0 || seq_total < LEN_2 || seq_total > LEN_4) begin
      held_count_next = 2'd0;
      seq_total_next  = LEN_NONE;
      do_lead         = 1'b1;
    end else if (!is_cont) begin
      // sequence cut short: each held byte errors, byte restarts as lead
      desc_next.pre   = held_count;
      held_count_next = 2'd0;
      seq_total_next  = LEN_NONE;
      do_lead         = 1'b1;
    end else if ({1'b0, held_count} + 3'd1 >= seq_total) begin
      held_count_next = 2'd0;
      seq_total_next  = LEN_NONE;
      if (fin_ok) begin
        desc_next.tail_on  = 1'b1;
        desc_next.tail_cp  = fin_cp;
        desc_next.tail_len = seq_total;
      end else begin
        desc_next.pre = held_count;
        do_lead       = 1'b1;
      end
    end else begin
      wr_store        = 1'b1;
      held_count_next = held_count + 2'd1;
    end

    // Lead byte handling
    if (do_lead) begin
      if (is_ascii) begin
        desc_next.tail_on = 1'b1;
        desc_next.tail_cp = {13'd0, b};
      end else if (lead_tot != LEN_NONE) begin
        wr_lead         = 1'b1;
        held_count_next = 2'd1;
        seq_total_next  = lead_tot;
      end else begin
        desc_next.tail_on  = 1'b1;
        desc_next.tail_bad = 1'b1;
      end
    end

    // End of text flushes whatever is still held
    if (bytes.in_last) begin
      post            = held_count_next;
      held_count_next = 2'd0;
      seq_total_next  = LEN_NONE;
    end

    desc_next.cnt = {1'b0, desc_next.pre} + {2'd0, desc_next.tail_on} + {1'b0, post};
    desc_next.eot = bytes.in_last;
  end

  // Sequence registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_total  <= LEN_NONE;
    end else if (in_fire) begin
      held_count <= held_count_next;
      seq_total  <= seq_total_next;
    end
  end

  // Held bytes, no reset: only entries below held_count are read
  always_ff @(posedge clk) begin
    if (in_fire && wr_lead) begin
      held[0] <= b;
    end else if (in_fire && wr_store) begin
      held[held_count] <= b;
    end
  end

  // Result register and drain index
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (in_fire) begin
      desc_valid <= desc_next.cnt != 3'd0;
      idx        <= 2'd0;
    end else if (out_done) begin
      desc_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (out_fire) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      desc <= desc_next;
    end
  end

  // Output word select: the tail word sits right after the pre errors
  assign tail_here          = desc.tail_on && (idx == desc.pre);
  assign codes.valid        = desc_valid;
  assign codes.code_point   = tail_here ? desc.tail_cp : '0;
  assign codes.bad_sequence = tail_here ? desc.tail_bad : 1'b1;
  assign codes.byte_length  = tail_here ? desc.tail_len : LEN_1;
  assign codes.end_of_text  = desc.eot && last_idx;

  // Checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> ({1'b0, idx} < desc.cnt))
    else $error("drain index beyond result count");

  a_held_consistent: assert property (@(posedge clk) disable iff (rst)
    (held_count != 2'd0) |-> ((seq_total >= LEN_2) && ({1'b0, held_count} < seq_total)))
    else $error("held count inconsistent with sequence length");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && bytes.in_last) |=> (held_count == 2'd0 && seq_total == LEN_NONE))
    else $error("state not cleared after end of text");

  a_no_accept_mid_drain: assert property (@(posedge clk) disable iff (rst)
    (desc_valid && !last_idx) |-> !bytes.ready)
    else $error("input taken while results pending");

endmodule

/* tb/sv/utf8_stream_decoder_tb.sv */
module utf8_stream_decoder_tb;
  import u8d_pkg::*;

  localparam int RUN_LIMIT   = 300000;
  localparam int TAIL_CYCLES = 20;
  localparam int RAND_BYTES  = 190;
  localparam int HOLD_AFTER  = 60;   // bytes taken before the long output hold-off
  localparam int HOLD_CYCLES = 120;

  // {in_last, in_byte}: ASCII NUL, 2/3/4-byte bounds, overlong, surrogate,
  // above max, stray continuation, invalid lead, break and text cut short
  localparam int N_DIRECTED = 27;
  localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
    9'h100,
    9'h0C2, 9'h080,
    9'h0C0, 9'h0AF,
    9'h0EF, 9'h0BF, 9'h0BF,
    9'h0ED, 9'h0A0, 9'h080,
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
    9'h0F4, 9'h090, 9'h080, 9'h080,
    9'h080,
    9'h0FF,
    9'h0F0, 9'h090, 9'h080, 9'h041,
    9'h0E1, 9'h180
  };

  typedef struct {
    logic [ByteW-1:0] b;
    logic             last;
    int               gap;
    bit               drain;   // wait until every code word is back first
  } text_byte_t;

  typedef struct {
    logic [CpW-1:0]  cp;
    logic            bad;
    logic [LenW-1:0] len;
    logic            eot;
  } code_word_t;

  logic clk;
  logic rst;

  u8d_in_if  bytes_if ();
  u8d_out_if codes_if ();

  utf8_stream_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes_if),
    .codes (codes_if)
  );

  text_byte_t       text_bytes [$];
  code_word_t       code_words_due [$];
  logic [ByteW-1:0] token_bytes [$];

  int bytes_total = 0;
  int texts_total = 0;
  int bytes_sent  = 0;
  int codes_due   = 0;
  int codes_done  = 0;
  int bad_words   = 0;
  int fail_count  = 0;
  int cycle_count = 0;

  // decoder state mirror
  logic [ByteW-1:0] held [3];
  logic [1:0]       held_n;
  logic [LenW-1:0]  seq_len;
  code_word_t       step_words [4];
  int               step_n;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- prediction ----------------

  function automatic void emit(logic [CpW-1:0] cp, logic bad, logic [LenW-1:0] len);
    code_word_t w;
    w.cp  = cp;
    w.bad = bad;
    w.len = len;
    w.eot = 1'b0;
    if (step_n < 4) step_words[step_n] = w;
    step_n++;
    if (bad) bad_words++;
  endfunction

  // one error word per held byte, then back to idle
  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) emit('0, 1'b1, LEN_1);
    held_n  = 0;
    seq_len = LEN_NONE;
  endfunction

  function automatic void open_lead(logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    n = LEN_NONE;
    if (!b[7]) emit({13'd0, b}, 1'b0, LEN_1);
    else if ((b & LEAD2_MASK) == LEAD2_TAG) n = LEN_2;
    else if ((b & LEAD3_MASK) == LEAD3_TAG) n = LEN_3;
    else if ((b & LEAD4_MASK) == LEAD4_TAG) n = LEN_4;
    else emit('0, 1'b1, LEN_1);
    if (n != LEN_NONE) begin
      held[0] = b;
      held_n  = 1;
      seq_len = n;
    end
  endfunction

  // assemble the codepoint from the held bytes and the final one, check range
  function automatic bit seq_value(logic [ByteW-1:0] b, output logic [CpW-1:0] v);
    case (seq_len)
      LEN_2: begin
        v = {10'd0, held[0][4:0], b[5:0]};
        return v >= MIN_2BYTE;
      end
      LEN_3: begin
        v = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
        return v >= MIN_3BYTE && !(v >= SURR_LO && v <= SURR_HI);
      end
      default: begin
        v = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
        return v >= MIN_4BYTE && v <= CP_MAX;
      end
    endcase
  endfunction

  function automatic int decode_byte(logic [ByteW-1:0] b, logic last);
    logic [CpW-1:0]  v;
    logic [LenW-1:0] n;
    step_n = 0;
    if (held_n == 0 || seq_len < LEN_2 || seq_len > LEN_4) begin
      held_n  = 0;
      seq_len = LEN_NONE;
      open_lead(b);
    end else if ((b & CONT_MASK) != CONT_TAG) begin
      flush_held();
      open_lead(b);
    end else if (held_n + 1 >= seq_len) begin
      n = seq_len;
      if (seq_value(b, v)) begin
        emit(v, 1'b0, n);
        held_n  = 0;
        seq_len = LEN_NONE;
      end else begin
        flush_held();
        open_lead(b);
      end
    end else begin
      held[held_n] = b;
      held_n++;
    end
    // end of text: flush whatever is still open as errors, tag the final word
    if (last) begin
      if (held_n > 0) flush_held();
      if (step_n > 0) step_words[step_n-1].eot = 1'b1;
    end
    for (int i = 0; i < step_n; i++) code_words_due.push_back(step_words[i]);
    return step_n;
  endfunction

  // ---------------- stimulus ----------------

  function automatic void queue_byte(logic [ByteW-1:0] b, logic last);
    text_byte_t t;
    t.b     = b;
    t.last  = last;
    // a run of back-to-back bytes in the middle of the random part
    t.gap   = (bytes_total >= 120 && bytes_total < 170) ? 0 : $urandom_range(0, 10);
    t.drain = (bytes_total == N_DIRECTED || bytes_total == 150);
    text_bytes.push_back(t);
    bytes_total++;
  endfunction

  function automatic void put_cp(logic [CpW-1:0] c, int n);
    case (n)
      1: token_bytes.push_back({1'b0, c[6:0]});
      2: begin
        token_bytes.push_back({3'b110, c[10:6]});
        token_bytes.push_back({2'b10, c[5:0]});
      end
      3: begin
        token_bytes.push_back({4'b1110, c[15:12]});
        token_bytes.push_back({2'b10, c[11:6]});
        token_bytes.push_back({2'b10, c[5:0]});
      end
      default: begin
        token_bytes.push_back({5'b11110, c[20:18]});
        token_bytes.push_back({2'b10, c[17:12]});
        token_bytes.push_back({2'b10, c[11:6]});
        token_bytes.push_back({2'b10, c[5:0]});
      end
    endcase
  endfunction

  // mostly well-formed characters, some raw noise, cut-short and bad-value forms
  function automatic void add_token();
    int unsigned kind, cp;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      n = $urandom_range(1, 4);
      case (n)
        1: cp = $urandom_range(0, 'h7F);
        2: cp = $urandom_range('h80, 'h7FF);
        3: begin
          cp = $urandom_range('h800, 'hFFFF);
          if (cp >= 'hD800 && cp <= 'hDFFF) cp -= 'h1000;
        end
        default: cp = $urandom_range('h10000, 'h10FFFF);
      endcase
      put_cp(CpW'(cp), n);
    end else if (kind < 80) begin
      token_bytes.push_back(ByteW'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      n = $urandom_range(2, 4);
      put_cp(CpW'($urandom_range(0, 'h1FFFFF)), n);
      repeat ($urandom_range(1, n - 1)) void'(token_bytes.pop_back());
    end else begin
      n = $urandom_range(2, 4);
      case (n)
        2: cp = $urandom_range(0, 'h7F);
        3: cp = $urandom_range(0, 1) ? $urandom_range(0, 'h7FF) : $urandom_range('hD800, 'hDFFF);
        default: cp = $urandom_range(0, 1) ? $urandom_range(0, 'hFFFF)
                                           : $urandom_range('h110000, 'h1FFFFF);
      endcase
      put_cp(CpW'(cp), n);
    end
  endfunction

  function automatic void add_text();
    repeat ($urandom_range(1, 8)) add_token();
    while (token_bytes.size() > 0) begin
      queue_byte(token_bytes[0], token_bytes.size() == 1);
      void'(token_bytes.pop_front());
    end
    texts_total++;
  endfunction

  // ---------------- byte driver ----------------

  int gap_count = 0;

  always @(posedge clk) begin
    logic took;
    logic offer;
    int   n;
    if (rst) begin
      bytes_if.valid <= 1'b0;
      gap_count = 0;
    end else begin
      took  = bytes_if.valid && bytes_if.ready;
      offer = bytes_if.valid && !took;
      if (took) begin
        n = decode_byte(bytes_if.in_byte, bytes_if.in_last);
        codes_due  <= codes_due + n;
        bytes_sent <= bytes_sent + 1;
      end
      if (!offer && text_bytes.size() > 0) begin
        if (gap_count < text_bytes[0].gap) begin
          gap_count++;
        end else if (!(text_bytes[0].drain && (took || codes_due != codes_done))) begin
          bytes_if.in_byte <= text_bytes[0].b;
          bytes_if.in_last <= text_bytes[0].last;
          void'(text_bytes.pop_front());
          gap_count = 0;
          offer = 1'b1;
        end
      end
      bytes_if.valid <= offer;
    end
  end

  // ---------------- code word monitor ----------------

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  int  stall_count = 0;
  int  hold_count  = 0;
  bit  hold_used   = 0;

  always @(posedge clk) begin
    code_word_t want;
    if (rst) begin
      codes_if.ready <= 1'b0;
    end else begin
      if (codes_if.valid && codes_if.ready) begin
        codes_done <= codes_done + 1;
        if (code_words_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, got cp %0h bad %0b len %0d eot %0b",
                   $time, codes_if.code_point, codes_if.bad_sequence,
                   codes_if.byte_length, codes_if.end_of_text);
        end else begin
          want = code_words_due.pop_front();
          check_field("code_point", 32'(want.cp), 32'(codes_if.code_point));
          check_field("bad_sequence", 32'(want.bad), 32'(codes_if.bad_sequence));
          check_field("byte_length", 32'(want.len), 32'(codes_if.byte_length));
          check_field("end_of_text", 32'(want.eot), 32'(codes_if.end_of_text));
        end
        // no stalls for a stretch of words mid-run
        stall_count = (codes_done >= 150 && codes_done < 260) ? 0 : $urandom_range(0, 10);
      end
      // one long hold-off so the decoder backs up into its input
      if (!hold_used && bytes_sent >= HOLD_AFTER) begin
        hold_used  = 1;
        hold_count = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
        hold_count--;
        codes_if.ready <= 1'b0;
      end else if (stall_count > 0) begin
        stall_count--;
        codes_if.ready <= 1'b0;
      end else begin
        codes_if.ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t: timeout, %0d of %0d bytes taken, %0d words still due",
               $time, bytes_sent, bytes_total, code_words_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst              = 1'b1;
    bytes_if.valid   = 1'b0;
    bytes_if.in_byte = '0;
    bytes_if.in_last = 1'b0;
    codes_if.ready   = 1'b0;
    held_n           = 0;
    seq_len          = LEN_NONE;
    foreach (held[i]) held[i] = '0;

    foreach (DIRECTED[i]) queue_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    texts_total = 2;
    while (bytes_total < N_DIRECTED + RAND_BYTES) add_text();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (bytes_sent != bytes_total) @(posedge clk);
    while (codes_done != codes_due) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (code_words_due.size() != 0) begin
      fail_count += code_words_due.size();
      $display("%0t: %0d expected words never came out", $time, code_words_due.size());
    end

    $display("Decoded %0d bytes in %0d texts into %0d words (%0d error words),",
             bytes_sent, texts_total, codes_done, bad_words);
    $display("with random gaps on both sides, one long output hold-off and idle drains.");
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
